@@ hdl/rmypr_pkg.sv @@
// ----------------------------------------------------------------------------
// rmypr_pkg: shared types and constants
// Widths, the arctangent table and the input scaling and output rounding
// helpers used by the rotation matrix to yaw, pitch and roll pipeline.
// ----------------------------------------------------------------------------
package rmypr_pkg;

  localparam int Iterations = 16;
  localparam int Guard      = 24;
  localparam int InW        = 18;
  // Working width: 18 bit input scaled by 2^24, plus CORDIC growth and negation.
  localparam int DW         = 46;
  // Angle width: 2^-23 degree units, up to about +/-1024 degrees.
  localparam int AW         = 34;

  localparam logic signed [AW-1:0] HalfTurn = AW'(64'sd1509949440);
  localparam logic signed [20:0]   InvGain  = 21'sd636751;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [AW-1:0] ang_t;

  typedef logic signed [AW-1:0] atan_tab_t [24];
  localparam atan_tab_t AtanTab = '{
    34'sd377487360, 34'sd222843801, 34'sd117744544, 34'sd59768969,
    34'sd30000467, 34'sd15014858, 34'sd7509261, 34'sd3754860,
    34'sd1877459, 34'sd938733, 34'sd469367, 34'sd234683,
    34'sd117342, 34'sd58671, 34'sd29335, 34'sd14668,
    34'sd7334, 34'sd3667, 34'sd1833, 34'sd917,
    34'sd458, 34'sd229, 34'sd115, 34'sd57
  };

  typedef struct packed {
    data_t x;
    data_t y;
    ang_t  z;
    logic  zero;
  } vec_t;

  // Payload carried through the yaw pipeline.
  typedef struct packed {
    vec_t  n;
    data_t n2;
    data_t o0;
    data_t o1;
    data_t a0;
    data_t a1;
  } yaw_t;

  // Payload carried through the pitch and roll pipeline.
  typedef struct packed {
    ang_t yaw;
    vec_t p;
    vec_t r;
  } pr_t;

  function automatic data_t sext_in(input logic [InW-1:0] v);
    sext_in = DW'($signed(v)) <<< Guard;
  endfunction

  function automatic logic [15:0] to_out(input ang_t a, input int lim);
    logic signed [AW-1:0] v;
    v = (a + AW'(32768)) >>> 16;
    if (v > AW'(lim)) v = AW'(lim);
    if (v < -AW'(lim)) v = -AW'(lim);
    to_out = v[15:0];
  endfunction

endpackage

@@ hdl/rmypr_if.sv @@
// ----------------------------------------------------------------------------
// rmypr_in_if / rmypr_out_if: request channels
// Valid and ready handshake with the matrix and angle payloads.
// ----------------------------------------------------------------------------
interface rmypr_in_if;
  logic        valid;
  logic        ready;
  logic [17:0] m00;
  logic [17:0] m10;
  logic [17:0] m20;
  logic [17:0] m01;
  logic [17:0] m11;
  logic [17:0] m02;
  logic [17:0] m12;
  modport source (output valid, m00, m10, m20, m01, m11, m02, m12, input ready);
  modport sink (input valid, m00, m10, m20, m01, m11, m02, m12, output ready);
endinterface

interface rmypr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] yaw_deg;
  logic [14:0] pitch_deg;
  logic [15:0] roll_deg;
  modport source (output valid, yaw_deg, pitch_deg, roll_deg, input ready);
  modport sink (input valid, yaw_deg, pitch_deg, roll_deg, output ready);
endinterface

@@ hdl/rmypr_yaw_stage.sv @@
// ----------------------------------------------------------------------------
// rmypr_yaw_stage: one registered yaw CORDIC iteration
// Vectors the first column and replays the same rotation on columns one, two.
// The iteration index arrives on step_i and is tied to a constant per instance.
// ----------------------------------------------------------------------------
module rmypr_yaw_stage import rmypr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  logic       valid_i,
  input  yaw_t       d_i,
  output logic       valid_o,
  output yaw_t       d_o
);

  yaw_t d_d, d_q;
  logic valid_q;

  always_comb begin
    logic up;
    d_d = d_i;
    up = (d_i.n.y >= 0);
    if (!d_i.n.zero) begin
      if (up) begin
        d_d.n.x = d_i.n.x + (d_i.n.y >>> step_i);
        d_d.n.y = d_i.n.y - (d_i.n.x >>> step_i);
        d_d.n.z = d_i.n.z + AtanTab[step_i];
        d_d.o0  = d_i.o0 + (d_i.o1 >>> step_i);
        d_d.o1  = d_i.o1 - (d_i.o0 >>> step_i);
        d_d.a0  = d_i.a0 + (d_i.a1 >>> step_i);
        d_d.a1  = d_i.a1 - (d_i.a0 >>> step_i);
      end else begin
        d_d.n.x = d_i.n.x - (d_i.n.y >>> step_i);
        d_d.n.y = d_i.n.y + (d_i.n.x >>> step_i);
        d_d.n.z = d_i.n.z - AtanTab[step_i];
        d_d.o0  = d_i.o0 - (d_i.o1 >>> step_i);
        d_d.o1  = d_i.o1 + (d_i.o0 >>> step_i);
        d_d.a0  = d_i.a0 - (d_i.a1 >>> step_i);
        d_d.a1  = d_i.a1 + (d_i.a0 >>> step_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

@@ hdl/rmypr_pr_stage.sv @@
// ----------------------------------------------------------------------------
// rmypr_pr_stage: one registered pitch and roll CORDIC iteration
// Two independent vectoring CORDIC slices running side by side.
// The iteration index arrives on step_i and is tied to a constant per instance.
// ----------------------------------------------------------------------------
module rmypr_pr_stage import rmypr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  logic       valid_i,
  input  pr_t        d_i,
  output logic       valid_o,
  output pr_t        d_o
);

  pr_t  d_d, d_q;
  logic valid_q;

  function automatic vec_t vstep(input vec_t v, input logic [4:0] s);
    vec_t r;
    r = v;
    if (!v.zero) begin
      if (v.y >= 0) begin
        r.x = v.x + (v.y >>> s);
        r.y = v.y - (v.x >>> s);
        r.z = v.z + AtanTab[s];
      end else begin
        r.x = v.x - (v.y >>> s);
        r.y = v.y + (v.x >>> s);
        r.z = v.z - AtanTab[s];
      end
    end
    return r;
  endfunction

  always_comb begin
    d_d   = d_i;
    d_d.p = vstep(d_i.p, step_i);
    d_d.r = vstep(d_i.r, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

@@ hdl/rotation_matrix_to_yaw_pitch_roll.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_yaw_pitch_roll: ZYX Euler angles from a rotation matrix
// Pipelined CORDIC that turns seven matrix elements into yaw, pitch and roll.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_if     sink       m00 m10 m20 m01 m11 m02 m12, 18 bit signed Q1.16
// out_if    source     yaw_deg 16b, pitch_deg 15b, roll_deg 16b, 1/128 degree
//
// One request is accepted per cycle while the output is not stalled. The
// pipeline is the yaw CORDIC followed by the pitch and roll CORDIC, each one
// register per iteration, plus the entry stage, two gain correction stages,
// the pitch and roll fold stage and the output stage.
// Reset clears all valid bits. The whole pipeline advances only when
// the output register is empty or being taken, so a stall holds every request
// in place.
// ----------------------------------------------------------------------------
module rotation_matrix_to_yaw_pitch_roll import rmypr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmypr_in_if.sink    in_if,
  rmypr_out_if.source out_if
);

  logic en;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // Entry stage: sign extend, scale, and fold the left half plane of column 0.
  logic v0_q;
  yaw_t y0_q;
  yaw_t y0_d;

  always_comb begin
    data_t n0, n1;
    logic  flip;
    n0 = sext_in(in_if.m00);
    n1 = sext_in(in_if.m10);
    flip = (n0 < 0);
    y0_d.n.zero = (n0 == '0) && (n1 == '0);
    y0_d.n2 = sext_in(in_if.m20);
    y0_d.n.z = '0;
    y0_d.n.x = n0;
    y0_d.n.y = n1;
    y0_d.o0 = sext_in(in_if.m01);
    y0_d.o1 = sext_in(in_if.m11);
    y0_d.a0 = sext_in(in_if.m02);
    y0_d.a1 = sext_in(in_if.m12);
    if (flip) begin
      y0_d.n.z = (n1 >= 0) ? HalfTurn : -HalfTurn;
      y0_d.n.x = -n0;
      y0_d.n.y = -n1;
      y0_d.o0 = -y0_d.o0;
      y0_d.o1 = -y0_d.o1;
      y0_d.a0 = -y0_d.a0;
      y0_d.a1 = -y0_d.a1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y0_q <= y0_d;
    end
  end

  // Yaw CORDIC chain.
  logic yv [Iterations+1];
  yaw_t yd [Iterations+1];
  assign yv[0] = v0_q;
  assign yd[0] = y0_q;

  for (genvar i = 0; i < Iterations; i++) begin : g_yaw
    rmypr_yaw_stage u_stage (
      .clk_i, .rst_ni, .en_i(en), .step_i(5'(i)),
      .valid_i(yv[i]), .d_i(yd[i]), .valid_o(yv[i+1]), .d_o(yd[i+1])
    );
  end

  // Gain correction, first half: the magnitude is split at bit 23 so that each
  // partial product stays narrow. Both partial products are registered here.
  logic               vg_q;
  logic signed [43:0] ph_d, ph_q;
  logic signed [44:0] pl_d, pl_q;
  ang_t               yawg_q;
  logic               zg_q;
  data_t              n2g_q, o1g_q, a1g_q;
  assign ph_d = $signed(yd[Iterations].n.x[DW-1:23]) * InvGain;
  assign pl_d = $signed({1'b0, yd[Iterations].n.x[22:0]}) * InvGain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= yv[Iterations];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q   <= ph_d;
      pl_q   <= pl_d;
      yawg_q <= yd[Iterations].n.zero ? '0 : yd[Iterations].n.z;
      zg_q   <= yd[Iterations].n.zero;
      n2g_q  <= yd[Iterations].n2;
      o1g_q  <= yd[Iterations].o1;
      a1g_q  <= yd[Iterations].a1;
    end
  end

  // Gain correction, second half: sum the partial products and floor.
  logic  vm_q;
  data_t mag_q;
  ang_t  yawm_q;
  logic  zm_q;
  data_t n2m_q, o1m_q, a1m_q;
  logic signed [DW+21-1:0] prod;
  assign prod = ((DW+21)'(ph_q) <<< 23) + (DW+21)'(pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= DW'(prod >>> 20);
      yawm_q <= yawg_q;
      zm_q   <= zg_q;
      n2m_q  <= n2g_q;
      o1m_q  <= o1g_q;
      a1m_q  <= a1g_q;
    end
  end

  // Pitch and roll entry: build the two vectors and fold their left halves.
  function automatic vec_t fold(input data_t x, input data_t y);
    vec_t r;
    r.zero = (x == '0) && (y == '0);
    r.z = '0;
    r.x = x;
    r.y = y;
    if (x < 0) begin
      r.z = (y >= 0) ? HalfTurn : -HalfTurn;
      r.x = -x;
      r.y = -y;
    end
    return r;
  endfunction

  logic v1_q;
  pr_t  p0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q.yaw <= yawm_q;
      p0_q.p   <= fold(zm_q ? data_t'(0) : mag_q, -n2m_q);
      p0_q.r   <= fold(o1m_q, -a1m_q);
    end
  end

  logic pv [Iterations+1];
  pr_t  pd [Iterations+1];
  assign pv[0] = v1_q;
  assign pd[0] = p0_q;

  for (genvar i = 0; i < Iterations; i++) begin : g_pr
    rmypr_pr_stage u_stage (
      .clk_i, .rst_ni, .en_i(en), .step_i(5'(i)),
      .valid_i(pv[i]), .d_i(pd[i]), .valid_o(pv[i+1]), .d_o(pd[i+1])
    );
  end

  // Output register: round half up and saturate.
  logic        vo_q;
  logic [15:0] yaw_q, roll_q;
  logic [14:0] pitch_q;
  logic [15:0] pitch_w;
  assign pitch_w = to_out(pd[Iterations].p.zero ? ang_t'(0) : pd[Iterations].p.z, 11520);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= pv[Iterations];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yaw_q   <= to_out(pd[Iterations].yaw, 23040);
      pitch_q <= pitch_w[14:0];
      roll_q  <= to_out(pd[Iterations].r.zero ? ang_t'(0) : pd[Iterations].r.z, 23040);
    end
  end

  assign out_if.valid     = vo_q;
  assign out_if.yaw_deg   = yaw_q;
  assign out_if.pitch_deg = pitch_q;
  assign out_if.roll_deg  = roll_q;

endmodule

@@ dv/tb_rmypr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rmypr_if: testbench request channel helpers
// The block's channel interfaces are compiled from the RTL tree. This file
// holds the request and result types that the driver, predictor and monitor share.
// ----------------------------------------------------------------------------
package tb_rmypr_types_pkg;

  typedef struct {
    logic [17:0] m00;
    logic [17:0] m10;
    logic [17:0] m20;
    logic [17:0] m01;
    logic [17:0] m11;
    logic [17:0] m02;
    logic [17:0] m12;
  } matrix_req_t;

  typedef struct {
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
  } angles_t;

endpackage

@@ dv/tb_rotation_matrix_to_yaw_pitch_roll.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_yaw_pitch_roll: self-checking testbench
// Drives matrix requests with random gaps, takes angle results with random
// stalls, and compares every result with a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_yaw_pitch_roll;
  import rmypr_pkg::*;
  import tb_rmypr_types_pkg::*;

  localparam int NumRandom = 1950;
  // Pipeline depth for 16 iterations, used only for the drain at the end.
  localparam int Latency   = 2 * Iterations + 5;
  localparam int CycleLimit = 400000;
  localparam logic [17:0] PosOne = 18'sd65536;
  localparam logic [17:0] NegOne = -18'sd65536;

  logic clk_i;
  logic rst_ni = 1'b0;

  rmypr_in_if  req_if ();
  rmypr_out_if ang_if ();

  rotation_matrix_to_yaw_pitch_roll u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if),
    .out_if (ang_if)
  );

  matrix_req_t pending_reqs[$];
  angles_t     expected_angles[$];
  int          mismatches = 0;
  int          cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Everything runs on 64 bit signed values; the inputs are scaled by
  // 2^24 so each CORDIC shift keeps plenty of fraction bits, and >>> on a signed
  // longint floors, which is what the hardware shifts do.
  // ---------------------------------------------------------------------------
  function automatic longint widen(logic [17:0] v);
    longint r;
    r = longint'($signed(v));
    return r * (64'sd1 << Guard);
  endfunction

  // Vectoring CORDIC on (x, y). Returns the angle in 2^-23 degree and hands back
  // the gained magnitude, the rotation directions and whether the vector was
  // folded out of the left half plane first.
  function automatic longint cordic_angle(longint x_in, longint y_in, output longint mag,
                                          output bit [23:0] dirs, output bit folded);
    longint x, y, z, xs, ys;
    x = x_in;
    y = y_in;
    z = 0;
    dirs = '0;
    folded = 1'b0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(HalfTurn) : -longint'(HalfTurn);
      x = -x;
      y = -y;
      folded = 1'b1;
    end
    for (int i = 0; i < Iterations; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(AtanTab[i]);
        dirs[i] = 1'b1;
      end else begin
        x = x - ys; y = y + xs; z -= longint'(AtanTab[i]);
      end
    end
    mag = x;
    return z;
  endfunction

  // Rotate a companion column by minus yaw, following the yaw CORDIC's decisions.
  function automatic void derotate(inout longint x, inout longint y, input bit [23:0] dirs,
                                   input bit folded);
    longint xs, ys;
    if (folded) begin
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Iterations; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (dirs[i]) begin
        x = x + ys; y = y - xs;
      end else begin
        x = x - ys; y = y + xs;
      end
    end
  endfunction

  // atan2 with the C convention that the zero vector has angle zero.
  function automatic longint safe_angle(longint x, longint y);
    longint    mag;
    bit [23:0] dirs;
    bit        folded;
    if (x == 0 && y == 0) return 0;
    return cordic_angle(x, y, mag, dirs, folded);
  endfunction

  // Round half up to 1/128 degree, then clamp to the field's range.
  function automatic longint to_degrees(longint a, longint lim);
    longint v;
    v = (a + 32768) >>> 16;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic angles_t predict_angles(matrix_req_t r);
    longint    nx, ny, nz, ox, oy, ax, ay;
    longint    yaw, pitch, roll, mag, pitch_den;
    bit [23:0] dirs;
    bit        folded;
    angles_t   res;
    nx = widen(r.m00); ny = widen(r.m10); nz = widen(r.m20);
    ox = widen(r.m01); oy = widen(r.m11);
    ax = widen(r.m02); ay = widen(r.m12);
    yaw = 0;
    pitch_den = 0;
    // A first column with no xy part leaves yaw at zero and skips the derotation.
    if (!(nx == 0 && ny == 0)) begin
      yaw = cordic_angle(nx, ny, mag, dirs, folded);
      pitch_den = (mag * longint'(InvGain)) >>> 20;
      derotate(ox, oy, dirs, folded);
      derotate(ax, ay, dirs, folded);
    end
    pitch = safe_angle(pitch_den, -nz);
    roll  = safe_angle(oy, -ay);
    res.yaw   = 16'(to_degrees(yaw, 23040));
    res.pitch = 15'(to_degrees(pitch, 11520));
    res.roll  = 16'(to_degrees(roll, 23040));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [17:0] q16(real v);
    return 18'($rtoi(v * 65536.0 + (v >= 0.0 ? 0.5 : -0.5)));
  endfunction

  function automatic logic [17:0] any_pattern();
    return 18'($urandom);
  endfunction

  function automatic logic [17:0] in_range();
    return 18'($urandom_range(131072) - 65536);
  endfunction

  task automatic queue_req(logic [17:0] a, logic [17:0] b, logic [17:0] c, logic [17:0] d,
                           logic [17:0] e, logic [17:0] f, logic [17:0] g);
    matrix_req_t r;
    r.m00 = a; r.m10 = b; r.m20 = c; r.m01 = d; r.m11 = e; r.m02 = f; r.m12 = g;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // A real rotation built from random Euler angles, so the three outputs land
  // in their useful ranges rather than in saturation.
  task automatic queue_rotation(real yaw_r, real pitch_r, real roll_r);
    real cy, sy, cp, sp, cr, sr;
    cy = $cos(yaw_r); sy = $sin(yaw_r);
    cp = $cos(pitch_r); sp = $sin(pitch_r);
    cr = $cos(roll_r); sr = $sin(roll_r);
    queue_req(q16(cy * cp), q16(sy * cp), q16(-sp),
              q16(cy * sp * sr - sy * cr), q16(sy * sp * sr + cy * cr),
              q16(cy * sp * cr + sy * sr), q16(sy * sp * cr - cy * sr));
  endtask

  function automatic real rand_angle(real span);
    return (real'($urandom_range(1000000)) / 1000000.0 * 2.0 - 1.0) * span;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one request at a time from the pending queue, with a random idle gap,
  // possibly zero, drawn per request. A zero gap keeps valid high.
  // ---------------------------------------------------------------------------
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_angles.insert(expected_angles.size(),
                               predict_angles(pending_reqs.pop_front()));
        gap = $urandom_range(8);
        if (gap == 0 && pending_reqs.size() > 0) begin
          req_if.valid <= 1'b1;
          {req_if.m00, req_if.m10, req_if.m20, req_if.m01, req_if.m11, req_if.m02,
           req_if.m12} <= {pending_reqs[0].m00, pending_reqs[0].m10, pending_reqs[0].m20,
                           pending_reqs[0].m01, pending_reqs[0].m11, pending_reqs[0].m02,
                           pending_reqs[0].m12};
        end else begin
          req_if.valid <= 1'b0;
          gap_left     <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!req_if.valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          req_if.valid <= 1'b1;
          {req_if.m00, req_if.m10, req_if.m20, req_if.m01, req_if.m11, req_if.m02,
           req_if.m12} <= {pending_reqs[0].m00, pending_reqs[0].m10, pending_reqs[0].m20,
                           pending_reqs[0].m01, pending_reqs[0].m11, pending_reqs[0].m02,
                           pending_reqs[0].m12};
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stalls on ready, and a field-by-field check of each result.
  // ---------------------------------------------------------------------------
  int stall_left;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t want;
    int      stall;
    if (!rst_ni) begin
      ang_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (ang_if.valid && ang_if.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("outstanding requests", 0, 1);
        end else begin
          want = expected_angles.pop_front();
          if (ang_if.yaw_deg !== want.yaw)
            report_mismatch("yaw", $signed(ang_if.yaw_deg), $signed(want.yaw));
          if (ang_if.pitch_deg !== want.pitch)
            report_mismatch("pitch", $signed(ang_if.pitch_deg), $signed(want.pitch));
          if (ang_if.roll_deg !== want.roll)
            report_mismatch("roll", $signed(ang_if.roll_deg), $signed(want.roll));
        end
        // A new random wait, possibly zero, is drawn for every result.
        stall = $urandom_range(8);
        if (stall > 0) begin
          stall_left   <= stall - 1;
          ang_if.ready <= 1'b0;
        end
      end else if (!ang_if.ready) begin
        if (stall_left > 0) stall_left <= stall_left - 1;
        else ang_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int r;

    // Directed: identity, all-zero, zero first column (yaw and pitch both
    // atan2(0,0)), each quadrant and both axis crossings for the left half plane
    // fold, pitch at +/-90 degrees, and the most extreme 18 bit patterns.
    queue_req(PosOne, '0, '0, '0, PosOne, '0, '0);
    queue_req('0, '0, '0, '0, '0, '0, '0);
    queue_req('0, '0, PosOne, '0, PosOne, PosOne, '0);
    queue_req('0, '0, NegOne, '0, PosOne, NegOne, '0);
    queue_req(NegOne, '0, '0, '0, NegOne, '0, '0);
    queue_req(NegOne, 18'sd1, '0, '0, NegOne, '0, '0);
    queue_req(NegOne, -18'sd1, '0, '0, NegOne, '0, '0);
    queue_req('0, PosOne, '0, NegOne, '0, '0, '0);
    queue_req('0, NegOne, '0, PosOne, '0, '0, '0);
    queue_req(PosOne, '0, '0, '0, NegOne, '0, '0);
    queue_req(PosOne, '0, '0, '0, '0, '0, PosOne);
    queue_req(18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000);
    queue_req(18'h20000, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF);
    queue_req(18'h3FFFF, '0, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    queue_req(18'h20000, 18'h1FFFF, '0, '0, '0, '0, '0);
    queue_req(18'h1, '0, 18'h20000, '0, 18'h1, '0, '0);
    queue_rotation(0.5, 0.3, -2.0);
    queue_rotation(-3.1, -1.2, 3.1);

    // Random: mostly genuine rotations, the rest matrices with elements in range
    // and raw 18 bit patterns so every bit of every field toggles.
    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(9);
      if (r < 6) begin
        queue_rotation(rand_angle(3.14159265), rand_angle(1.5707963), rand_angle(3.14159265));
      end else if (r < 8) begin
        queue_req(in_range(), in_range(), in_range(), in_range(), in_range(), in_range(),
                  in_range());
      end else begin
        queue_req(any_pattern(), any_pattern(), any_pattern(), any_pattern(), any_pattern(),
                  any_pattern(), any_pattern());
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !req_if.valid);
    wait (expected_angles.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);

    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rmypr_pkg.sv
hdl/rmypr_if.sv
hdl/rmypr_yaw_stage.sv
hdl/rmypr_pr_stage.sv
hdl/rotation_matrix_to_yaw_pitch_roll.sv
dv/tb_rmypr_if.sv
dv/tb_rotation_matrix_to_yaw_pitch_roll.sv
